// ----- sv/smtp_reply_parser_core_defines.svh -----
// ----------------------------------------------------------------------------
// SMTP reply parser assertion macros
// Shared concurrent assertion forms for the reply parser checkers.
// ----------------------------------------------------------------------------
`ifndef SMTP_REPLY_PARSER_CORE_DEFINES_SVH
`define SMTP_REPLY_PARSER_CORE_DEFINES_SVH

// Condition must never be seen outside reset
`define SRP_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("srp checker: forbidden condition seen");

// Antecedent in one cycle implies consequent in the next
`define SRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srp checker: next-cycle rule broken");

// Antecedent implies consequent in the same cycle
`define SRP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srp checker: same-cycle rule broken");

`endif

// ----- sv/srp_pkg.sv -----
// ----------------------------------------------------------------------------
// SMTP reply parser package
// Types, codes and constants shared by the reply parser modules.
// ----------------------------------------------------------------------------
package srp_pkg;

   // Default sizing
   localparam int LINE_LIMIT_MAX_DEF = 1024;
   localparam int QUEUE_DEPTH_DEF    = 4;

   // Register file
   localparam int CFG_W          = 11;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam logic [CFG_W-1:0] CFG_RESET_MAX_LINE = 11'd512;
   localparam logic CSR_IDX_MAX_LINE = 1'b0;

   // Line rules
   localparam int MIN_LINE   = 6;
   localparam int SEP_POS    = 3;
   localparam int TEXT_START = 4;

   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Result event codes
   typedef enum logic [1:0] {
      EV_TEXT  = 2'd0,
      EV_LINE  = 2'd1,
      EV_ERROR = 2'd2
   } srp_event_type;

   // One result beat, less the reply code
   typedef struct packed {
      srp_event_type ev;
      logic [7:0]    txt;
      logic          fin;
   } srp_res_type;

   // Results caused by one input byte
   typedef struct packed {
      logic          two_res;
      srp_res_type   res0;
      srp_res_type   res1;
      logic [23:0]   code;
   } srp_entry_type;

   // Queue status towards front and back
   typedef struct packed {
      logic empty;
      logic full;
   } srp_qstat_type;

endpackage

// ----- sv/srp_front.sv -----
// ----------------------------------------------------------------------------
// SMTP reply parser front end
// Tracks line state per received byte and builds the result entry it causes.
// ----------------------------------------------------------------------------
module srp_front #(
   parameter int LINE_LIMIT_MAX = srp_pkg::LINE_LIMIT_MAX_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [srp_pkg::CFG_W-1:0]   max_line_bytes,
   input  logic                        byte_take,
   input  logic [7:0]                  rx_byte,
   output logic                        ent_push,
   output srp_pkg::srp_entry_type      ent
);
   import srp_pkg::*;

   localparam int POS_W = $clog2(LINE_LIMIT_MAX) + 1;
   localparam int LIM_W = (POS_W > CFG_W) ? POS_W : CFG_W;
   localparam logic [LIM_W-1:0] LIM_LO = LIM_W'(MIN_LINE);
   localparam logic [LIM_W-1:0] LIM_HI = LIM_W'(LINE_LIMIT_MAX);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [23:0]      code_ff, code_in;
   logic [7:0]       sep_ff, sep_in;
   logic             held_ff, held_in;
   logic             first_ff, first_in;

   logic [LIM_W-1:0] cfg_ext, limit_w;
   logic [POS_W-1:0] limit, pos_inc;
   logic             lf_end, line_ok, sep_final, cr_rel, lim_hit;
   logic             main_vld;
   srp_res_type      cr_res, main_res;

   // Saturated line limit
   always_comb begin
      cfg_ext = LIM_W'(max_line_bytes);
      if (cfg_ext < LIM_LO) begin
         limit_w = LIM_LO;
      end else if (cfg_ext > LIM_HI) begin
         limit_w = LIM_HI;
      end else begin
         limit_w = cfg_ext;
      end
      limit = limit_w[POS_W-1:0];
   end

   assign pos_inc   = pos_ff + 1'b1;
   assign lf_end    = held_ff && (rx_byte == CHAR_LF);
   assign sep_final = (sep_ff == CHAR_SPACE);
   assign line_ok   = (pos_inc >= POS_W'(MIN_LINE)) &&
                      ((sep_ff == CHAR_DASH) || sep_final);
   assign cr_rel    = held_ff && !first_ff && (pos_ff >= POS_W'(TEXT_START + 1));
   assign lim_hit   = (pos_inc >= limit);

   // Next line state and results for this byte
   always_comb begin
      pos_in   = pos_ff;
      code_in  = code_ff;
      sep_in   = sep_ff;
      held_in  = held_ff;
      first_in = first_ff;
      main_vld = 1'b0;
      main_res = '{ev: EV_TEXT, txt: 8'd0, fin: 1'b0};
      cr_res   = '{ev: EV_TEXT, txt: CHAR_CR, fin: 1'b0};

      if (lf_end) begin
         // CR LF closes the line
         main_vld = 1'b1;
         if (line_ok) begin
            main_res = '{ev: EV_LINE, txt: 8'd0, fin: sep_final};
            first_in = sep_final;
         end else begin
            main_res = '{ev: EV_ERROR, txt: 8'd0, fin: 1'b0};
            first_in = 1'b1;
         end
         pos_in  = '0;
         sep_in  = '0;
         held_in = 1'b0;
      end else begin
         held_in = 1'b0;
         // Reply code capture on the first line
         if (first_ff && (pos_ff < POS_W'(SEP_POS))) begin
            case (pos_ff[1:0])
               2'd0:    code_in[7:0]   = rx_byte;
               2'd1:    code_in[15:8]  = rx_byte;
               default: code_in[23:16] = rx_byte;
            endcase
         end
         if (pos_ff == POS_W'(SEP_POS)) begin
            sep_in = rx_byte;
         end
         if (lim_hit) begin
            main_vld = 1'b1;
            main_res = '{ev: EV_ERROR, txt: 8'd0, fin: 1'b0};
            first_in = 1'b1;
            pos_in   = '0;
            sep_in   = '0;
         end else begin
            pos_in = pos_inc;
            if (rx_byte == CHAR_CR) begin
               held_in = 1'b1;
            end else if (!first_ff && (pos_ff >= POS_W'(TEXT_START))) begin
               main_vld = 1'b1;
               main_res = '{ev: EV_TEXT, txt: rx_byte, fin: 1'b0};
            end
         end
      end
   end

   // Entry packing: a released CR always goes first
   always_comb begin
      ent.code = code_ff;
      if (!lf_end && cr_rel) begin
         ent.res0    = cr_res;
         ent.res1    = main_res;
         ent.two_res = main_vld;
         ent_push    = byte_take;
      end else begin
         ent.res0    = main_res;
         ent.res1    = main_res;
         ent.two_res = 1'b0;
         ent_push    = byte_take && main_vld;
      end
   end

   // Line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         code_ff  <= '0;
         sep_ff   <= '0;
         held_ff  <= 1'b0;
         first_ff <= 1'b1;
      end else if (byte_take) begin
         pos_ff   <= pos_in;
         code_ff  <= code_in;
         sep_ff   <= sep_in;
         held_ff  <= held_in;
         first_ff <= first_in;
      end
   end

endmodule

// ----- sv/srp_queue.sv -----
// ----------------------------------------------------------------------------
// SMTP reply parser entry queue
// Small FIFO of result entries between the front and back ends.
// ----------------------------------------------------------------------------
module srp_queue #(
   parameter int DEPTH = srp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  srp_pkg::srp_entry_type   wr_ent,
   input  logic                     rd_en,
   output srp_pkg::srp_entry_type   rd_ent,
   output srp_pkg::srp_qstat_type   qstat
);
   import srp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   srp_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_wr, do_rd;

   assign qstat.empty = (cnt_ff == '0);
   assign qstat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign do_wr       = wr_en && !qstat.full;
   assign do_rd       = rd_en && !qstat.empty;
   assign rd_ent      = slot_ff[rd_ptr_ff];

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_ent;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// ----- sv/srp_back.sv -----
// ----------------------------------------------------------------------------
// SMTP reply parser back end
// Splits each queued entry into one or two result beats.
// ----------------------------------------------------------------------------
module srp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  srp_pkg::srp_entry_type   head,
   input  srp_pkg::srp_qstat_type   qstat,
   input  logic                     beat_pop,
   output logic                     head_pop,
   output logic [1:0]               event_res,
   output logic [7:0]               text_byte,
   output logic [7:0]               code_char_0,
   output logic [7:0]               code_char_1,
   output logic [7:0]               code_char_2,
   output logic                     final_line,
   output logic                     last
);
   import srp_pkg::*;

   logic        sub_ff, sub_in;
   srp_res_type cur;
   logic        take;

   // Current beat of the head entry
   assign cur  = sub_ff ? head.res1 : head.res0;
   assign last = !head.two_res || sub_ff;
   assign take = beat_pop && !qstat.empty;

   assign event_res   = cur.ev;
   assign text_byte   = cur.txt;
   assign final_line  = cur.fin;
   assign code_char_0 = (cur.ev == EV_LINE) ? head.code[7:0]   : 8'd0;
   assign code_char_1 = (cur.ev == EV_LINE) ? head.code[15:8]  : 8'd0;
   assign code_char_2 = (cur.ev == EV_LINE) ? head.code[23:16] : 8'd0;

   // Retire the entry on its last beat
   always_comb begin
      head_pop = 1'b0;
      sub_in   = sub_ff;
      if (take) begin
         if (last) begin
            head_pop = 1'b1;
            sub_in   = 1'b0;
         end else begin
            sub_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

// ----- sv/smtp_reply_parser_core.sv -----
// One byte of a server reply is taken per cycle while req_full is low; each
// byte yields zero, one or two result beats (a held CR released as text, then
// a text byte, line-complete or protocol-error event). The front end computes
// its next line state combinationally, so input runs at one byte per clock
// while req_full is low; a small queue between front and back lets results
// stall without stopping input until it fills, and a two-beat entry leaves it
// with its second beat. Each entry is registered in the queue before output.
// ----------------------------------------------------------------------------
// SMTP reply parser core
// Top level: register port, front end, entry queue and back end.
// ----------------------------------------------------------------------------
module smtp_reply_parser_core #(
   parameter int LINE_LIMIT_MAX = srp_pkg::LINE_LIMIT_MAX_DEF,
   parameter int QUEUE_DEPTH    = srp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [7:0]                      req_rx_byte,
   // result channel
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [1:0]                      rsp_event_res,
   output logic [7:0]                      rsp_text_byte,
   output logic [7:0]                      rsp_code_char_0,
   output logic [7:0]                      rsp_code_char_1,
   output logic [7:0]                      rsp_code_char_2,
   output logic                            rsp_final_line,
   output logic                            rsp_last,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [srp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [srp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [srp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import srp_pkg::*;

   logic [CFG_W-1:0] max_line_ff;
   logic             csr_wr, byte_take, ent_push, head_pop;
   srp_entry_type    ent, head;
   srp_qstat_type    qstat;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MAX_LINE) ?
                       CSR_DATA_W'(max_line_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff <= CFG_RESET_MAX_LINE;
      end else if (csr_wr && (csr_paddr[2] == CSR_IDX_MAX_LINE)) begin
         max_line_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   // Channel handshakes
   assign req_full  = qstat.full;
   assign rsp_empty = qstat.empty;
   assign byte_take = req_push && !req_full;

   srp_front #(
      .LINE_LIMIT_MAX (LINE_LIMIT_MAX)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .max_line_bytes (max_line_ff),
      .byte_take      (byte_take),
      .rx_byte        (req_rx_byte),
      .ent_push       (ent_push),
      .ent            (ent)
   );

   srp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (ent_push),
      .wr_ent (ent),
      .rd_en  (head_pop),
      .rd_ent (head),
      .qstat  (qstat)
   );

   srp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .qstat       (qstat),
      .beat_pop    (rsp_pop),
      .head_pop    (head_pop),
      .event_res   (rsp_event_res),
      .text_byte   (rsp_text_byte),
      .code_char_0 (rsp_code_char_0),
      .code_char_1 (rsp_code_char_1),
      .code_char_2 (rsp_code_char_2),
      .final_line  (rsp_final_line),
      .last        (rsp_last)
   );

endmodule

// ----- sv/srp_checker.sv -----
// ----------------------------------------------------------------------------
// SMTP reply parser port checker
// Watches the result ports of the core and flags malformed beats.
// ----------------------------------------------------------------------------
`include "smtp_reply_parser_core_defines.svh"

module srp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [1:0] rsp_event_res,
   input logic [7:0] rsp_text_byte,
   input logic [7:0] rsp_code_char_0,
   input logic [7:0] rsp_code_char_1,
   input logic [7:0] rsp_code_char_2,
   input logic       rsp_final_line,
   input logic       rsp_last
);
   import srp_pkg::*;

   // A waiting beat not taken stays put
   `SRP_ASSERT_NEXT(a_beat_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_event_res) && $stable(rsp_text_byte) && $stable(rsp_last))

   // Only the three defined events appear
   `SRP_ASSERT_NEVER(a_event_known, clock, reset, !rsp_empty && (rsp_event_res != EV_TEXT) && (rsp_event_res != EV_LINE) && (rsp_event_res != EV_ERROR))

   // Final flag and code only travel with a completed line
   `SRP_ASSERT_IMPLY(a_line_fields, clock, reset, !rsp_empty && (rsp_event_res != EV_LINE), !rsp_final_line && (rsp_code_char_0 == 8'd0) && (rsp_code_char_1 == 8'd0) && (rsp_code_char_2 == 8'd0))

   // Line and error events end the results of their byte and carry no text
   `SRP_ASSERT_IMPLY(a_event_closes, clock, reset, !rsp_empty && (rsp_event_res != EV_TEXT), rsp_last && (rsp_text_byte == 8'd0))

endmodule

bind smtp_reply_parser_core srp_checker u_srp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_event_res   (rsp_event_res),
   .rsp_text_byte   (rsp_text_byte),
   .rsp_code_char_0 (rsp_code_char_0),
   .rsp_code_char_1 (rsp_code_char_1),
   .rsp_code_char_2 (rsp_code_char_2),
   .rsp_final_line  (rsp_final_line),
   .rsp_last        (rsp_last)
);
